@@ rtl/core/fldc_pkg.sv @@
// Shared constants, result type, a CRC-12 helper and the sync-word helper for the lane deframer.
// No dependencies; fldc_parse, fldc_out_reg and the top level import this package.
package fldc_pkg;

  localparam int DATA_WORDS = 128;
  localparam int LANES      = 4;

  // A frame is the sync word, lane ID, count, the data words and the CRC word.
  localparam int FRAME_LAST = DATA_WORDS + 3;
  localparam int POS_W      = $clog2(FRAME_LAST + 1);

  localparam logic [11:0] CRC_POLY   = 12'h80F;
  localparam logic [15:0] SYNC_BASE  = 16'hFA35;
  localparam logic [15:0] SYNC_STEP  = 16'h0111;
  localparam logic [3:0]  ID_NIBBLE  = 4'hE;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [1:0]  lane;
    logic [8:0]  channel;
    logic [15:0] pcm_sample;
    logic [11:0] cycle_count;
    logic        crc_ok;
    logic        lane_id_bad;
    logic        sequence_gap;
    logic [3:0]  drop_count;
  } result_t;

  // Twelve shift steps of the CRC register after folding in one word.
  // This is a fixed XOR network; each output bit is an XOR of a few input bits.
  function automatic logic [11:0] crc12_fold(logic [11:0] crc, logic [11:0] word);
    logic [11:0] r;
    r = crc ^ word;
    for (int k = 0; k < 12; k++) begin
      if (r[11]) begin
        r = {r[10:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[10:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] lane_sync(int lane_num);
    return 16'(SYNC_BASE + 16'(SYNC_STEP * lane_num));
  endfunction

endpackage

@@ rtl/core/fldc_in_reg.sv @@
// Input register stage of the lane deframer: holds one received word.
// Does not use fldc_pkg.
module fldc_in_reg (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] stream_word,
  input  logic        word_take,
  output logic        word_valid,
  output logic [15:0] word
);

  logic accept;

  assign in_ready = !word_valid || word_take;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (accept) begin
      word_valid <= 1'b1;
    end else if (word_take) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word <= stream_word;
    end
  end

endmodule

@@ rtl/core/fldc_parse.sv @@
// Frame parser of the lane deframer: sync hunt, header checks, CRC and per-lane
// sequence state. Uses fldc_pkg for constants, the result type and the CRC and sync helpers.
module fldc_parse
  import fldc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        word_valid,
  input  logic [15:0] word,
  input  logic        res_ready,
  output logic        word_take,
  output logic        res_valid,
  output result_t     res
);

  logic              in_frame, in_frame_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [1:0]        cur_lane, cur_lane_next;
  logic [11:0]       crc, crc_next;
  logic [11:0]       count_hold, count_hold_next;
  logic              id_bad, id_bad_next;
  logic              seq_gap, seq_gap_next;
  logic [3:0]        drop, drop_next;
  logic [11:0]       last_count [4];
  logic [3:0]        count_seen;

  logic [11:0]       val;
  logic [11:0]       folded;
  logic              produce;
  logic              last_word;
  logic [POS_W-1:0]  idx;
  logic [POS_W-1:0]  half;
  logic              hit;
  logic [1:0]        hit_lane;
  logic [15:0]       hit_sync;
  logic              bad_now;
  logic [11:0]       count_inc;

  assign val       = word[11:0];
  assign folded    = crc12_fold(crc, val);
  assign produce   = in_frame && (pos >= POS_W'(3));
  assign last_word = (pos == POS_W'(FRAME_LAST));
  assign word_take = word_valid && (res_ready || !produce);
  assign idx       = pos - POS_W'(3);
  assign half      = idx >> 1;
  assign count_inc = last_count[cur_lane] + 12'd1;
  assign bad_now   = (word[15:12] != ID_NIBBLE) || (word[5:0] != ~word[11:6]) ||
                     (word[7:6] != cur_lane);

  always_comb begin
    hit      = 1'b0;
    hit_lane = 2'd0;
    hit_sync = 16'd0;
    for (int l = 0; l < LANES; l++) begin
      if (!hit && word == lane_sync(l)) begin
        hit      = 1'b1;
        hit_lane = 2'(l);
        hit_sync = lane_sync(l);
      end
    end
  end

  always_comb begin
    in_frame_next   = in_frame;
    pos_next        = pos;
    cur_lane_next   = cur_lane;
    crc_next        = crc;
    count_hold_next = count_hold;
    id_bad_next     = id_bad;
    seq_gap_next    = seq_gap;
    drop_next       = drop;
    if (!in_frame) begin
      if (hit) begin
        in_frame_next = 1'b1;
        pos_next      = POS_W'(1);
        cur_lane_next = hit_lane;
        crc_next      = crc12_fold(12'd0, hit_sync[11:0]);
      end
    end else if (pos == POS_W'(1)) begin
      id_bad_next  = bad_now;
      seq_gap_next = 1'b0;
      drop_next    = bad_now ? 4'd0 : word[11:8];
      crc_next     = folded;
      pos_next     = pos + POS_W'(1);
    end else if (pos == POS_W'(2)) begin
      crc_next        = folded;
      count_hold_next = val;
      if (count_seen[cur_lane] && count_inc != val) begin
        seq_gap_next = 1'b1;
      end
      pos_next = pos + POS_W'(1);
    end else if (!last_word) begin
      crc_next = folded;
      pos_next = pos + POS_W'(1);
    end else begin
      in_frame_next = 1'b0;
      pos_next      = '0;
    end
  end

  always_comb begin
    res             = '0;
    res_valid       = word_valid && produce;
    res.lane        = cur_lane;
    res.cycle_count = count_hold;
    if (last_word) begin
      res.kind         = KIND_VERDICT;
      res.crc_ok       = (val == crc);
      res.lane_id_bad  = id_bad;
      res.sequence_gap = seq_gap;
      res.drop_count   = drop;
    end else begin
      res.kind       = KIND_SAMPLE;
      res.channel    = {cur_lane, idx[0], 6'd0} + 9'(half);
      res.pcm_sample = {~val[11], val[10:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      pos        <= '0;
      cur_lane   <= 2'd0;
      crc        <= 12'd0;
      count_hold <= 12'd0;
      id_bad     <= 1'b0;
      seq_gap    <= 1'b0;
      drop       <= 4'd0;
      count_seen <= 4'd0;
      for (int l = 0; l < 4; l++) begin
        last_count[l] <= 12'd0;
      end
    end else if (word_take) begin
      in_frame   <= in_frame_next;
      pos        <= pos_next;
      cur_lane   <= cur_lane_next;
      crc        <= crc_next;
      count_hold <= count_hold_next;
      id_bad     <= id_bad_next;
      seq_gap    <= seq_gap_next;
      drop       <= drop_next;
      if (in_frame && pos == POS_W'(2)) begin
        last_count[cur_lane] <= val;
        count_seen[cur_lane] <= 1'b1;
      end
    end
  end

  a_hunt_pos_zero: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> pos == '0)
    else $error("position counter not cleared while hunting");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (pos >= POS_W'(1) && pos <= POS_W'(FRAME_LAST)))
    else $error("position counter out of frame range");

  a_verdict_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (word_take && res_valid && res.kind == KIND_VERDICT) |=> !in_frame)
    else $error("frame did not close after the verdict");

  a_count_marks_lane: assert property (@(posedge clk) disable iff (rst)
    (word_take && in_frame && pos == POS_W'(2)) |=> count_seen[$past(cur_lane)])
    else $error("count word did not mark its lane as seen");

endmodule

@@ rtl/core/fldc_out_reg.sv @@
// Result register of the lane deframer: holds one result until it is taken.
// Uses fldc_pkg for the result type.
module fldc_out_reg
  import fldc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  input  result_t res,
  input  logic    word_take,
  output logic    res_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic load;

  assign res_ready = !out_valid || out_ready;
  assign load      = res_valid && word_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

@@ rtl/core/framed_lane_deframer_crc12_unit.sv @@
// Channel   Handshake             Payload
// input     in_valid / in_ready   stream_word
// output    out_valid / out_ready kind, lane, channel, pcm_sample, cycle_count,
//                                 crc_ok, lane_id_bad, sequence_gap, drop_count
//
// One word is taken per cycle unless a stalled result holds it back. A word passes
// through the input register and the single-pass parse logic, and its result is held in
// the result register. Reset clears frame state, per-lane counts and both valid flags.
// A stalled result holds the output; words that give no result keep flowing.
// Top level of the lane deframer; uses fldc_pkg, fldc_in_reg, fldc_parse, fldc_out_reg.
module framed_lane_deframer_crc12_unit
  import fldc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] stream_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [1:0]  lane,
  output logic [8:0]  channel,
  output logic signed [15:0] pcm_sample,
  output logic [11:0] cycle_count,
  output logic        crc_ok,
  output logic        lane_id_bad,
  output logic        sequence_gap,
  output logic [3:0]  drop_count
);

  logic        word_valid;
  logic [15:0] word;
  logic        word_take;
  logic        res_ready;
  logic        res_valid;
  result_t     res;
  result_t     out_res;

  fldc_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_word (stream_word),
    .word_take   (word_take),
    .word_valid  (word_valid),
    .word        (word)
  );

  fldc_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word       (word),
    .res_ready  (res_ready),
    .word_take  (word_take),
    .res_valid  (res_valid),
    .res        (res)
  );

  fldc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .word_take (word_take),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign kind         = out_res.kind;
  assign lane         = out_res.lane;
  assign channel      = out_res.channel;
  assign pcm_sample   = out_res.pcm_sample;
  assign cycle_count  = out_res.cycle_count;
  assign crc_ok       = out_res.crc_ok;
  assign lane_id_bad  = out_res.lane_id_bad;
  assign sequence_gap = out_res.sequence_gap;
  assign drop_count   = out_res.drop_count;

endmodule
